@@ rtl/core/rgbg_pkg.sv @@
// Shared types and constants for the RGB 3x3 Gaussian blur core.
// Depends on nothing; imported by every module of the core.
package rgbg_pkg;

  localparam int WIDTH    = 256;
  localparam int DIVISOR  = 16;
  localparam int ROW_LEN  = WIDTH + 2;
  localparam int COL_W    = $clog2(ROW_LEN);
  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Sum of the 3x3 weights is 16, so a channel sum needs 12 bits.
  localparam int SUM_W    = 12;
  // Divide by DIVISOR as multiply by a rounded-up reciprocal and shift.
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = 25;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [NUM_CH-1:0][7:0] pix_t;

  // One line-store entry: the same column of the two previous rows.
  typedef struct packed {
    pix_t older;
    pix_t prev;
  } col_t;

  typedef struct packed {
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_in_row;
  } out_pix_t;

endpackage

@@ rtl/core/rgbg_line_ram.sv @@
// Line store: one entry per padded column holding the two previous rows.
// Synchronous memory, one read and one write port, registered read data.
// Depends on rgbg_pkg.
module rgbg_line_ram (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [rgbg_pkg::COL_W-1:0] rd_addr,
  output rgbg_pkg::col_t           rd_data,
  input  logic                     wr_en,
  input  logic [rgbg_pkg::COL_W-1:0] wr_addr,
  input  rgbg_pkg::col_t           wr_data
);
  import rgbg_pkg::*;

  col_t mem [ROW_LEN];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

@@ rtl/core/rgbg_out_fifo.sv @@
// Result queue between the blur pipeline and the output channel.
// Depends on rgbg_pkg.
module rgbg_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rgbg_pkg::out_pix_t push_data,
  input  logic               pop,
  output logic               not_empty,
  output rgbg_pkg::out_pix_t head
);
  import rgbg_pkg::*;

  out_pix_t             entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     count_r;

  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/rgb_gaussian_blur_3x3_core.sv @@
// RGB 3x3 Gaussian blur over padded raster rows; top level of the core.
// Uses rgbg_pkg, rgbg_line_ram and rgbg_out_fifo.
// Throughput: one pixel per cycle while in_ready is high; the line store takes one
// read and one write per pixel. A result passes the line store read, window, sum and
// product registers and the result queue before out_valid shows it. Reset (rst_n,
// synchronous) clears column, row count, pipeline valids and the result queue; the line store is not cleared.
module rgb_gaussian_blur_3x3_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbg_pkg::in_pix_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbg_pkg::out_pix_t out_data
);
  import rgbg_pkg::*;

  typedef struct packed {
    pix_t older;
    pix_t prev;
    pix_t cur;
  } win_col_t;

  // Weighted [1 2 1; 2 4 2; 1 2 1] sum of one channel over the window.
  function automatic logic [SUM_W-1:0] chan_sum(input win_col_t a, input win_col_t b,
                                                input win_col_t c, input logic [1:0] ch);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a.older[ch]) + (SUM_W'(b.older[ch]) << 1) + SUM_W'(c.older[ch])
      + (SUM_W'(a.prev[ch]) << 1) + (SUM_W'(b.prev[ch]) << 2)
      + (SUM_W'(c.prev[ch]) << 1)
      + SUM_W'(a.cur[ch]) + (SUM_W'(b.cur[ch]) << 1) + SUM_W'(c.cur[ch]);
    return s;
  endfunction

  // Input side state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       rows_r;
  logic [FIFO_AW:0] pending_r;
  logic             in_fire;
  logic             out_fire;
  logic             emit;
  logic             last_col;

  // Stage 1: line store data returns
  logic             s1_valid_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_px_r;
  col_t             rd_data;
  col_t             wr_data;

  // Window: three columns, oldest first
  win_col_t         win_r [3];
  logic             s2_valid_r;
  logic             s2_last_r;

  // Stage 3: channel sums; stage 4: reciprocal products
  logic [SUM_W-1:0]  sum_r  [NUM_CH];
  logic              s3_valid_r;
  logic              s3_last_r;
  logic [PROD_W-1:0] prod_r [NUM_CH];
  logic              s4_valid_r;
  logic              s4_last_r;
  out_pix_t          push_data;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  // Hold back requests once every queue slot is spoken for.
  assign in_ready = (pending_r < (FIFO_AW+1)'(FIFO_DEPTH));
  assign last_col = (col_r == COL_W'(ROW_LEN - 1));
  assign emit     = (rows_r == 2'd2) && (col_r >= COL_W'(2));
  assign col_nxt  = last_col ? '0 : col_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      rows_r    <= '0;
      pending_r <= '0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        // Advance the filled-row count at row end, saturate at two.
        if (last_col && rows_r != 2'd2) begin
          rows_r <= rows_r + 1'b1;
        end
      end
      case ({in_fire && emit, out_fire})
        2'b10:   pending_r <= pending_r + 1'b1;
        2'b01:   pending_r <= pending_r - 1'b1;
        default: pending_r <= pending_r;
      endcase
    end
  end

  // Read this column's two previous rows; write back shifted by one row on
  // the next cycle. The same column comes back only a whole row later, so
  // the write always lands before the next read of that entry.
  assign wr_data.older = rd_data.prev;
  assign wr_data.prev  = s1_px_r;

  rgbg_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= {in_data.in_blue, in_data.in_green, in_data.in_red};
      s1_col_r  <= col_r;
      s1_emit_r <= emit;
      s1_last_r <= last_col;
    end
    // Shift the window one column; the edge-column guard keeps stale
    // columns from the previous row out of any result.
    if (s1_valid_r) begin
      win_r[0]       <= win_r[1];
      win_r[1]       <= win_r[2];
      win_r[2].older <= rd_data.older;
      win_r[2].prev  <= rd_data.prev;
      win_r[2].cur   <= s1_px_r;
    end
    s2_last_r <= s1_last_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_r[ch]  <= chan_sum(win_r[0], win_r[1], win_r[2], 2'(ch));
      prod_r[ch] <= PROD_W'(sum_r[ch]) * PROD_W'(RECIP);
    end
    s3_last_r <= s2_last_r;
    s4_last_r <= s3_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r && s1_emit_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // Quotient keeps its low 8 bits.
  assign push_data.out_red     = prod_r[CH_RED][RECIP_SH +: 8];
  assign push_data.out_green   = prod_r[CH_GREEN][RECIP_SH +: 8];
  assign push_data.out_blue    = prod_r[CH_BLUE][RECIP_SH +: 8];
  assign push_data.last_in_row = s4_last_r;

  rgbg_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s4_valid_r),
    .push_data (push_data),
    .pop       (out_fire),
    .not_empty (out_valid),
    .head      (out_data)
  );

endmodule
